// ===== sv/sle_pkg.sv =====
`default_nettype none

package sle_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	// result status
	localparam logic ST_DONE = 1'b0;
	localparam logic ST_FULL = 1'b1;

	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

	localparam int CNT_OUT_W = 5;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] value;
	} in_word_t;

	typedef struct packed {
		logic                 status;
		logic [CNT_OUT_W-1:0] greater_count;
		logic [CNT_OUT_W-1:0] removed_count;
		logic [CNT_OUT_W-1:0] entry_total;
		logic signed [31:0]   smallest;
		logic signed [31:0]   largest;
	} out_word_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DELETE
	} cell_cmd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_REPORT
	} sle_state_t;

	// broadcast to every cell
	typedef struct packed {
		cell_cmd_t          cmd;
		logic               any_eq;
		logic signed [31:0] value;
	} cell_ctl_t;

	// what a cell shows its neighbors and the controller
	typedef struct packed {
		logic               valid;
		logic               le;
		logic               ge;
		logic               eq;
		logic signed [31:0] entry;
	} cell_flag_t;

endpackage

`default_nettype wire

// ===== sv/sorted_list_engine.sv =====
// sorted list engine: ascending store of signed 32-bit words in a row of cells
// a taken input word passes through EXEC and REPORT into the output register;
// a remove stays in EXEC while an equal entry is left, one leaving per cycle
// no new word is taken before the engine is back in IDLE after loading the
// result word, which waits in REPORT while out_stall holds an earlier one
// reset: arst_n clears cell valid bits, entry count and control, not stored values
`default_nettype none

module sorted_list_engine #(
	parameter int CAPACITY = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire sle_pkg::in_word_t  in_word,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output sle_pkg::out_word_t      out_word
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	// control
	sle_pkg::sle_state_t state_q, state_d;
	logic [1:0]          op_q;
	logic signed [31:0]  val_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       removed_q;
	logic                status_q;

	logic                accept;
	logic                load_out;
	logic                do_insert;
	logic                do_delete;
	logic                set_full;

	// cell row
	sle_pkg::cell_ctl_t  ctl;
	sle_pkg::cell_flag_t flag  [CAPACITY];
	sle_pkg::cell_flag_t prev_f[CAPACITY];
	sle_pkg::cell_flag_t next_f[CAPACITY];
	logic [CAPACITY-1:0] eq_vec;
	logic                any_eq;

	// report
	logic [CAPACITY-1:0] bound_vec;
	logic [CAPACITY-1:0] last_vec;
	logic [IW-1:0]       bound_idx;
	logic [CW-1:0]       greater;
	logic signed [31:0]  last_entry;

	sle_pkg::out_word_t  out_word_q;
	logic                out_valid_q;

	assign accept = in_valid && !in_stall;

	// ---------------------------------------------------------------- cells
	assign any_eq = |eq_vec;

	always_comb begin
		ctl.cmd    = sle_pkg::CELL_HOLD;
		ctl.any_eq = any_eq;
		ctl.value  = val_q;
		if (do_insert) begin
			ctl.cmd = sle_pkg::CELL_INSERT;
		end else if (do_delete) begin
			ctl.cmd = sle_pkg::CELL_DELETE;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		// cell 0 sees a virtual neighbor below every value
		if (i == 0) begin : g_first
			assign prev_f[i] = '{valid: 1'b1, le: 1'b1, ge: 1'b0, eq: 1'b0,
				entry: '0};
		end else begin : g_mid
			assign prev_f[i] = flag[i-1];
		end
		// past the last cell there is only empty space
		if (i == CAPACITY - 1) begin : g_last
			assign next_f[i] = '{valid: 1'b0, le: 1'b0, ge: 1'b0, eq: 1'b0,
				entry: '0};
			assign last_vec[i] = flag[i].valid;
		end else begin : g_inner
			assign next_f[i] = flag[i+1];
			assign last_vec[i] = flag[i].valid && !flag[i+1].valid;
		end

		// first entry strictly above the value: its predecessor is not above
		assign bound_vec[i] = flag[i].valid && !flag[i].le && prev_f[i].le;
		assign eq_vec[i]    = flag[i].eq;

		sle_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.prev   (prev_f[i]),
			.next   (next_f[i]),
			.flag   (flag[i])
		);
	end

	// one-hot boundary to index, and one-hot last entry to its value
	always_comb begin
		bound_idx  = '0;
		last_entry = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (bound_vec[i]) begin
				bound_idx = bound_idx | IW'(i);
			end
			if (last_vec[i]) begin
				last_entry = last_entry | flag[i].entry;
			end
		end
	end

	// entries above the value run from the boundary to the end of the list
	assign greater = (|bound_vec) ? (count_q - CW'(bound_idx)) : '0;

	// ---------------------------------------------------------------- control
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sle_pkg::S_IDLE: begin
				if (accept) begin
					state_d = sle_pkg::S_EXEC;
				end
			end
			sle_pkg::S_EXEC: begin
				// a remove keeps stepping while an equal entry is left
				if (!(op_q == sle_pkg::OP_REMOVE && any_eq)) begin
					state_d = sle_pkg::S_REPORT;
				end
			end
			sle_pkg::S_REPORT: begin
				if (load_out) begin
					state_d = sle_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sle_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		do_insert = 1'b0;
		do_delete = 1'b0;
		set_full  = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			sle_pkg::S_IDLE: begin
				in_stall = 1'b0;
			end
			sle_pkg::S_EXEC: begin
				if (op_q == sle_pkg::OP_INSERT) begin
					if (count_q == CW'(CAPACITY)) begin
						set_full = 1'b1;
					end else begin
						do_insert = 1'b1;
					end
				end else if (op_q == sle_pkg::OP_REMOVE) begin
					do_delete = any_eq;
				end
			end
			sle_pkg::S_REPORT: begin
				load_out = !out_valid_q || !out_stall;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sle_pkg::S_IDLE;
			count_q   <= '0;
			removed_q <= '0;
			status_q  <= sle_pkg::ST_DONE;
		end else begin
			state_q <= state_d;
			if (accept) begin
				removed_q <= '0;
				status_q  <= sle_pkg::ST_DONE;
			end
			if (set_full) begin
				status_q <= sle_pkg::ST_FULL;
			end
			if (do_insert) begin
				count_q <= count_q + 1'b1;
			end
			if (do_delete) begin
				count_q   <= count_q - 1'b1;
				removed_q <= removed_q + 1'b1;
			end
		end
	end

	// operand word held for the whole item
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= in_word.opcode;
			val_q <= in_word.value;
		end
	end

	// ---------------------------------------------------------------- output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_word_q.status        <= status_q;
			out_word_q.greater_count <= sle_pkg::CNT_OUT_W'(greater);
			out_word_q.removed_count <= sle_pkg::CNT_OUT_W'(removed_q);
			out_word_q.entry_total   <= sle_pkg::CNT_OUT_W'(count_q);
			out_word_q.smallest      <= flag[0].valid ? flag[0].entry : sle_pkg::INT_MIN;
			out_word_q.largest       <= (count_q != '0) ? last_entry : sle_pkg::INT_MIN;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

`default_nettype wire

// ===== sv/sle_cell.sv =====
`default_nettype none

module sle_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sle_pkg::cell_ctl_t ctl,
	input  wire sle_pkg::cell_flag_t prev,
	input  wire sle_pkg::cell_flag_t next,
	output sle_pkg::cell_flag_t     flag
);

	logic signed [31:0] entry_q;
	logic               valid_q;
	logic signed [31:0] entry_d;
	logic               valid_d;

	always_comb begin
		flag.valid = valid_q;
		flag.entry = entry_q;
		flag.le    = valid_q && (entry_q <= ctl.value);
		flag.ge    = valid_q && (entry_q >= ctl.value);
		flag.eq    = valid_q && (entry_q == ctl.value);
	end

	always_comb begin
		entry_d = entry_q;
		valid_d = valid_q;
		unique case (ctl.cmd)
			sle_pkg::CELL_HOLD: begin
			end
			sle_pkg::CELL_INSERT: begin
				// entries not above the value stay, the rest move one cell up, the value fills the gap
				if (!flag.le) begin
					if (prev.le) begin
						entry_d = ctl.value;
						valid_d = 1'b1;
					end else begin
						entry_d = prev.entry;
						valid_d = prev.valid;
					end
				end
			end
			sle_pkg::CELL_DELETE: begin
				// close the gap of one equal entry
				if (ctl.any_eq && flag.ge) begin
					entry_d = next.entry;
					valid_d = next.valid;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	import sle_pkg::*;

	// store depth, kept equal to the block's parameter
	localparam int LIST_DEPTH = 16;

	// codes that the package leaves unnamed
	localparam logic [1:0] OP_SPARE = 2'd3;   // unused opcode, acts as a query

	localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

	localparam int CLK_HALF    = 5;
	localparam int PHASE_ITEMS = 320;
	// longest remove deletes all 16 entries, leave room for a stalled receiver
	localparam int DRAIN_CYCLES = 40;
	localparam int TIMEOUT_NS   = 5_000_000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	in_word_t  in_word   = '0;
	logic      out_stall = 1'b0;
	logic      in_stall;
	logic      out_valid;
	out_word_t out_word;

	// idle and stall chances in percent, set per phase
	int idle_pct  = 0;
	int stall_pct = 0;

	// shadow of the store as the block should hold it
	logic signed [31:0] list_vals [LIST_DEPTH];
	int                 list_len = 0;

	// result words still owed by the block, oldest first
	out_word_t pending_results [$];
	int        mismatch_count = 0;
	int        results_seen   = 0;

	// one directed row: the word to send and, where obvious, the result typed in
	typedef struct {
		logic [1:0]         op;
		logic signed [31:0] val;
		bit                 typed;
		out_word_t          want;
	} dir_row_t;

	// empty store, extremes, every opcode, duplicates, full store, multi remove
	dir_row_t steps [25] = '{
		// empty after reset: nothing greater, both ends read most negative
		'{OP_QUERY,  32'sd0,  1'b1, '{ST_DONE, 5'd0, 5'd0, 5'd0, INT_MIN, INT_MIN}},
		// remove from an empty store deletes nothing
		'{OP_REMOVE, 32'sd5,  1'b1, '{ST_DONE, 5'd0, 5'd0, 5'd0, INT_MIN, INT_MIN}},
		// spare opcode behaves as a query
		'{OP_SPARE,  -32'sd1, 1'b1, '{ST_DONE, 5'd0, 5'd0, 5'd0, INT_MIN, INT_MIN}},
		// most negative value stored, still reads the same at both ends
		'{OP_INSERT, INT_MIN, 1'b1, '{ST_DONE, 5'd0, 5'd0, 5'd1, INT_MIN, INT_MIN}},
		'{OP_INSERT, INT_MAX, 1'b1, '{ST_DONE, 5'd0, 5'd0, 5'd2, INT_MIN, INT_MAX}},
		'{OP_QUERY,  INT_MIN, 1'b1, '{ST_DONE, 5'd1, 5'd0, 5'd2, INT_MIN, INT_MAX}},
		'{OP_INSERT, 32'sd0,  1'b0, '0},
		'{OP_INSERT, 32'sd0,  1'b0, '0},
		'{OP_INSERT, -32'sd1, 1'b0, '0},
		'{OP_INSERT, 32'sd1,  1'b0, '0},
		// two equal entries go with one remove
		'{OP_REMOVE, 32'sd0,  1'b0, '0},
		// fill up with one repeated value
		'{OP_INSERT, 32'sd7,  1'b0, '0},
		'{OP_INSERT, 32'sd7,  1'b0, '0},
		'{OP_INSERT, 32'sd7,  1'b0, '0},
		'{OP_INSERT, 32'sd7,  1'b0, '0},
		'{OP_INSERT, 32'sd7,  1'b0, '0},
		'{OP_INSERT, 32'sd7,  1'b0, '0},
		'{OP_INSERT, 32'sd7,  1'b0, '0},
		'{OP_INSERT, 32'sd7,  1'b0, '0},
		'{OP_INSERT, 32'sd7,  1'b0, '0},
		'{OP_INSERT, 32'sd7,  1'b0, '0},
		'{OP_INSERT, 32'sd7,  1'b0, '0},
		'{OP_INSERT, 32'sd7,  1'b0, '0},
		// store full: refused, nothing moves
		'{OP_INSERT, 32'sd7,  1'b1, '{ST_FULL, 5'd1, 5'd0, 5'd16, INT_MIN, INT_MAX}},
		// twelve equal entries leave one per cycle
		'{OP_REMOVE, 32'sd7,  1'b0, '0}
	};

	sorted_list_engine #(
		.CAPACITY(LIST_DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

	always #(CLK_HALF) clk = ~clk;

	// receiver back pressure, redrawn every cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// apply one accepted word to the shadow store and return the result it owes
	function automatic out_word_t apply_to_list(in_word_t w);
		out_word_t          r;
		logic signed [31:0] v;
		int                 pos;
		int                 wr;
		int                 k;
		int                 removed;
		int                 above;
		r       = '0;
		v       = w.value;
		removed = 0;
		above   = 0;
		r.status = ST_DONE;
		if (w.opcode == OP_INSERT) begin
			if (list_len >= LIST_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// equal values land behind the ones already there
				pos = 0;
				while (pos < list_len && list_vals[pos] <= v)
					pos++;
				for (k = list_len; k > pos; k--)
					list_vals[k] = list_vals[k - 1];
				list_vals[pos] = v;
				list_len++;
			end
		end else if (w.opcode == OP_REMOVE) begin
			wr = 0;
			for (k = 0; k < list_len; k++) begin
				if (list_vals[k] == v) begin
					removed++;
				end else begin
					list_vals[wr] = list_vals[k];
					wr++;
				end
			end
			list_len = wr;
		end
		for (k = 0; k < list_len; k++)
			if (list_vals[k] > v)
				above++;
		r.greater_count = above[CNT_OUT_W-1:0];
		r.removed_count = removed[CNT_OUT_W-1:0];
		r.entry_total   = list_len[CNT_OUT_W-1:0];
		if (list_len == 0) begin
			r.smallest = INT_MIN;
			r.largest  = INT_MIN;
		end else begin
			r.smallest = list_vals[0];
			r.largest  = list_vals[list_len - 1];
		end
		return r;
	endfunction

	// operand mix: small pool for duplicates, extremes, values already stored, anything
	function automatic logic signed [31:0] pick_value();
		int k;
		k = $urandom_range(9);
		if (k <= 3)
			return 32'(int'($urandom_range(7)) - 3);
		if (k == 4) begin
			case ($urandom_range(5))
				0:       return INT_MIN;
				1:       return INT_MAX;
				2:       return INT_MIN + 32'sd1;
				3:       return INT_MAX - 32'sd1;
				4:       return -32'sd1;
				default: return 32'sd0;
			endcase
		end
		if (k <= 6 && list_len > 0)
			return list_vals[$urandom_range(list_len - 1)];
		return $urandom;
	endfunction

	task automatic flag_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%t: %s", $realtime, msg);
	endtask

	// offer one word, hold it until taken, then log what it must produce
	task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
		out_word_t pred;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		pred = apply_to_list(w);
		pending_results.push_back(typed ? want : pred);
	endtask

	// result side: every taken word is matched against the oldest expectation
	always @(posedge clk) begin : check_results
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				flag_error($sformatf("result word %0d arrived with none expected",
					results_seen));
			end else begin
				want = pending_results.pop_front();
				if (out_word.status !== want.status
						|| out_word.greater_count !== want.greater_count
						|| out_word.removed_count !== want.removed_count
						|| out_word.entry_total !== want.entry_total
						|| out_word.smallest !== want.smallest
						|| out_word.largest !== want.largest)
					flag_error($sformatf({"result word %0d: exp st=%0d gt=%0d rm=%0d n=%0d",
						" min=%0d max=%0d, got st=%0d gt=%0d rm=%0d n=%0d min=%0d max=%0d"},
						results_seen, want.status, want.greater_count,
						want.removed_count, want.entry_total, want.smallest, want.largest,
						out_word.status, out_word.greater_count, out_word.removed_count,
						out_word.entry_total, out_word.smallest, out_word.largest));
			end
		end
	end

	// stimulus: directed rows, then random bursts over four idling phases
	initial begin : stimulus
		in_word_t           w;
		int                 ph;
		int                 sent;
		int                 burst_kind;
		int                 burst_len;
		int                 roll;
		logic signed [31:0] burst_value;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			w.opcode = steps[i].op;
			w.value  = steps[i].val;
			send_word(w, steps[i].typed, steps[i].want);
		end

		for (ph = 0; ph < 4; ph++) begin
			// no idling, sender gaps, receiver stalls, then both
			case (ph)
				0:       begin idle_pct = 0;  stall_pct = 0;  end
				1:       begin idle_pct = 51; stall_pct = 0;  end
				2:       begin idle_pct = 0;  stall_pct = 51; end
				default: begin idle_pct = 15; stall_pct = 15; end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				// bursts lean toward filling or draining so both ends get reached
				burst_kind  = $urandom_range(9);
				burst_len   = $urandom_range(40, 8);
				burst_value = pick_value();
				repeat (burst_len) begin
					roll = $urandom_range(99);
					if (burst_kind <= 3)
						w.opcode = roll < 75 ? OP_INSERT : (roll < 88 ? OP_REMOVE : OP_QUERY);
					else if (burst_kind <= 6)
						w.opcode = roll < 70 ? OP_REMOVE : (roll < 85 ? OP_INSERT : OP_QUERY);
					else if (burst_kind <= 8)
						w.opcode = roll < 34 ? OP_INSERT : (roll < 67 ? OP_REMOVE : OP_QUERY);
					else
						w.opcode = 2'($urandom_range(3));

					if (burst_kind == 9)
						w.value = $urandom;
					else if (w.opcode == OP_REMOVE && list_len > 0 && $urandom_range(9) < 7)
						w.value = list_vals[$urandom_range(list_len - 1)];
					else if (burst_kind <= 3 && $urandom_range(9) < 3)
						w.value = burst_value;   // runs of one value for long removes
					else
						w.value = pick_value();
					send_word(w, 1'b0, '0);
					sent++;
				end
			end
		end
		in_valid <= 1'b0;

		// drain, then give a late extra word time to show up
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("PASS sorted_list_engine");
		end else begin
			if (pending_results.size() != 0)
				flag_error($sformatf("%0d result words never arrived",
					pending_results.size()));
			$display("FAIL sorted_list_engine");
		end
		$finish;
	end

	// hard stop if the block hangs
	initial begin
		#(TIMEOUT_NS);
		$display("FAIL sorted_list_engine");
		$finish;
	end

endmodule
